### rtl/mct_pkg.sv
// Shared types and constants for the multichannel compare timer.
// No dependencies; every other file of the block imports this package.
package mct_pkg;

  // Block geometry
  localparam int CHANNELS      = 5;
  localparam int TIMER_BITS    = 16;
  localparam int CHAN_BITS     = 3;
  localparam int PRESCALE_BITS = 8;
  localparam int PERIOD_BITS   = 16;
  localparam int ACTION_BITS   = 2;
  localparam int SEL_BITS      = 2;

  // Action codes (code 3 is unused and changes nothing)
  localparam logic [ACTION_BITS-1:0] ACT_TICK = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_SET  = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_ARM  = 2'd2;

  // Prescaler select codes
  localparam logic [SEL_BITS-1:0] PRE_DIV1   = 2'd0;
  localparam logic [SEL_BITS-1:0] PRE_DIV8   = 2'd1;
  localparam logic [SEL_BITS-1:0] PRE_DIV64  = 2'd2;
  localparam logic [SEL_BITS-1:0] PRE_DIV256 = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [ACTION_BITS-1:0] action;
    logic [CHAN_BITS-1:0]   channel;
    logic [PERIOD_BITS-1:0] period;
  } mct_in_t;

  // Result transaction
  typedef struct packed {
    logic [CHANNELS-1:0]   fired_mask;
    logic [CHANNELS-1:0]   pending_mask;
    logic [CHANNELS-1:0]   pin_levels;
    logic [TIMER_BITS-1:0] timer_value;
  } mct_out_t;

  // Common control broadcast from the top level to every channel
  typedef struct packed {
    logic                  inc;        // timer increments this cycle
    logic [TIMER_BITS-1:0] count_now;  // timer before the update
    logic [TIMER_BITS-1:0] count_nxt;  // timer after the update
    logic [TIMER_BITS-1:0] step_new;   // period - 1 for a set action
  } mct_chan_ctrl_t;

  // Per-channel status back to the top level
  typedef struct packed {
    logic fired;
    logic flag_nxt;
    logic pin_nxt;
    logic armed;
    logic flag;
  } mct_chan_stat_t;

  // Ticks per timer count, one bit wider than the prescale counter
  function automatic logic [PRESCALE_BITS:0] prescale_limit(input logic [SEL_BITS-1:0] sel);
    logic [PRESCALE_BITS:0] lim;
    unique case (sel)
      PRE_DIV1:   lim = 9'd1;
      PRE_DIV8:   lim = 9'd8;
      PRE_DIV64:  lim = 9'd64;
      PRE_DIV256: lim = 9'd256;
      default:    lim = 9'd1;
    endcase
    return lim;
  endfunction

endpackage

### rtl/mct_timebase.sv
// Prescaler and free-running timer of the multichannel compare timer.
// Depends on mct_pkg.
module mct_timebase import mct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick,
  input  logic [SEL_BITS-1:0]   prescale_sel,
  output logic [TIMER_BITS-1:0] timer_r,
  output logic [TIMER_BITS-1:0] timer_nxt,
  output logic                  inc
);

  logic [PRESCALE_BITS-1:0] prescale_count_r;
  logic [PRESCALE_BITS-1:0] prescale_count_nxt;
  logic [PRESCALE_BITS:0]   count_plus;

  // Prescale compare and timer increment
  always_comb begin
    count_plus         = {1'b0, prescale_count_r} + 1'b1;
    inc                = 1'b0;
    prescale_count_nxt = prescale_count_r;
    timer_nxt          = timer_r;
    if (tick) begin
      if (count_plus >= prescale_limit(prescale_sel)) begin
        inc                = 1'b1;
        prescale_count_nxt = '0;
        timer_nxt          = timer_r + 1'b1;
      end else begin
        prescale_count_nxt = count_plus[PRESCALE_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_count_r <= '0;
      timer_r          <= '0;
    end else begin
      prescale_count_r <= prescale_count_nxt;
      timer_r          <= timer_nxt;
    end
  end

endmodule

### rtl/mct_channel.sv
// One output compare channel: compare and step registers, arm, flag, pin.
// Depends on mct_pkg.
module mct_channel import mct_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  mct_chan_ctrl_t ctrl,
  input  logic           set_en,
  input  logic           arm_en,
  output mct_chan_stat_t stat
);

  logic [TIMER_BITS-1:0] compare_r, compare_nxt;
  logic [TIMER_BITS-1:0] step_r, step_nxt;
  logic                  armed_r, armed_nxt;
  logic                  flag_r, flag_nxt;
  logic                  pin_r, pin_nxt;
  logic                  match;
  logic                  fired;

  // Set, arm and compare-match update
  always_comb begin
    compare_nxt = compare_r;
    step_nxt    = step_r;
    armed_nxt   = armed_r;
    flag_nxt    = flag_r;
    pin_nxt     = pin_r;
    match       = ctrl.inc && (compare_r == ctrl.count_nxt);
    fired       = 1'b0;
    if (set_en) begin
      step_nxt    = ctrl.step_new;
      compare_nxt = ctrl.count_now + ctrl.step_new;
      armed_nxt   = 1'b0;
      flag_nxt    = 1'b0;
      pin_nxt     = 1'b1;
    end else if (arm_en) begin
      flag_nxt  = 1'b0;
      armed_nxt = 1'b1;
    end else if (match) begin
      pin_nxt = 1'b0;
      if (armed_r) begin
        fired       = 1'b1;
        compare_nxt = compare_r + step_r;
      end else begin
        flag_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compare_r <= '1;
      step_r    <= '1;
      armed_r   <= 1'b0;
      flag_r    <= 1'b0;
      pin_r     <= 1'b1;
    end else begin
      compare_r <= compare_nxt;
      step_r    <= step_nxt;
      armed_r   <= armed_nxt;
      flag_r    <= flag_nxt;
      pin_r     <= pin_nxt;
    end
  end

  assign stat.fired    = fired;
  assign stat.flag_nxt = flag_nxt;
  assign stat.pin_nxt  = pin_nxt;
  assign stat.armed    = armed_r;
  assign stat.flag     = flag_r;

endmodule

### rtl/multichannel_compare_timer.sv
// Top level of the multichannel compare timer: input register, timebase,
// compare channels and result register. Depends on mct_pkg, mct_timebase, mct_channel.
//
//   channel  | handshake          | payload
//   ---------+--------------------+--------------------------------------------
//   input    | in_valid/in_stall  | in_data: action, channel, period
//   result   | out_valid/out_stall| out_data: fired, pending, pins, timer value
//   config   | cfg_we             | cfg_data: prescale select
//
// Each transaction passes through the input register and then the result register;
// one transaction a cycle is sustained, set by the single update stage, while the result side does not stall.
// Synchronous active-low reset clears all timer and channel state; there is no
// clearing pass. A stall on the result side holds the result register and
// backs up into the input register; the input side stalls only when both are full.
module multichannel_compare_timer import mct_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mct_in_t             in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mct_out_t            out_data,
  input  logic                cfg_we,
  input  logic [SEL_BITS-1:0] cfg_data
);

  logic                  a_valid_r;
  mct_in_t               a_item_r;
  logic                  out_valid_r;
  mct_out_t              out_data_r;
  logic [SEL_BITS-1:0]   prescale_sel_r;
  logic                  adv;
  logic                  tick;
  logic [TIMER_BITS-1:0] timer_r;
  logic [TIMER_BITS-1:0] timer_nxt;
  logic                  inc;
  mct_chan_ctrl_t        ctrl;
  mct_chan_stat_t        stat [CHANNELS];
  logic [CHANNELS-1:0]   fired_vec;
  logic [CHANNELS-1:0]   flag_nxt_vec;
  logic [CHANNELS-1:0]   pin_nxt_vec;
  logic [CHANNELS-1:0]   armed_vec;
  logic [CHANNELS-1:0]   flag_vec;

  // Flow control: the update stage moves when the result register is free
  assign adv      = a_valid_r && !(out_valid_r && out_stall);
  assign in_stall = a_valid_r && !adv;
  assign tick     = adv && (a_item_r.action == ACT_TICK);

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (!in_stall) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      a_item_r <= in_data;
    end
  end

  // Prescale select register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_sel_r <= PRE_DIV1;
    end else if (cfg_we) begin
      prescale_sel_r <= cfg_data;
    end
  end

  mct_timebase u_timebase (
    .clk          (clk),
    .rst_n        (rst_n),
    .tick         (tick),
    .prescale_sel (prescale_sel_r),
    .timer_r      (timer_r),
    .timer_nxt    (timer_nxt),
    .inc          (inc)
  );

  // Broadcast to the channels
  assign ctrl.inc       = inc;
  assign ctrl.count_now = timer_r;
  assign ctrl.count_nxt = timer_nxt;
  assign ctrl.step_new  = a_item_r.period - 1'b1;

  for (genvar k = 0; k < CHANNELS; k++) begin : g_chan
    logic sel_hit;
    assign sel_hit = (a_item_r.channel == CHAN_BITS'(k));

    mct_channel u_channel (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .set_en (adv && sel_hit && (a_item_r.action == ACT_SET)),
      .arm_en (adv && sel_hit && (a_item_r.action == ACT_ARM)),
      .stat   (stat[k])
    );

    assign fired_vec[k]    = stat[k].fired;
    assign flag_nxt_vec[k] = stat[k].flag_nxt;
    assign pin_nxt_vec[k]  = stat[k].pin_nxt;
    assign armed_vec[k]    = stat[k].armed;
    assign flag_vec[k]     = stat[k].flag;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.fired_mask   <= fired_vec;
      out_data_r.pending_mask <= flag_nxt_vec;
      out_data_r.pin_levels   <= pin_nxt_vec;
      out_data_r.timer_value  <= timer_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Only a tick transaction can fire a channel
  a_fire_on_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (a_item_r.action != ACT_TICK)) |-> (fired_vec == '0))
    else $error("channel fired on a non-tick transaction");

  // A channel that fires must be armed
  a_fire_needs_arm: assert property (@(posedge clk) disable iff (!rst_n)
    ((fired_vec & ~armed_vec) == '0))
    else $error("unarmed channel fired");

  // An armed channel never holds a pending flag
  a_flag_arm_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    ((flag_vec & armed_vec) == '0))
    else $error("pending flag set on an armed channel");

  // The timer only moves on a tick transaction
  a_timer_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (!tick) |=> (timer_r == $past(timer_r)))
    else $error("timer moved without a tick");

endmodule

### verif/tb_top.sv
// Self-checking testbench for multichannel_compare_timer: directed, prescaler, back-pressure
// and random tests against a cycle-free model of the timer. Depends on mct_pkg.
module tb_top;
  import mct_pkg::*;

  localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
  localparam int IDLE_PCT = 11;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mct_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  mct_out_t            out_data;
  logic                cfg_we    = 1'b0;
  logic [SEL_BITS-1:0] cfg_data  = PRE_DIV1;

  multichannel_compare_timer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timer model state
  logic [TIMER_BITS-1:0] tmr_count;
  int unsigned           tick_count;
  logic [TIMER_BITS-1:0] cmp_val  [CHANNELS];
  logic [TIMER_BITS-1:0] step_val [CHANNELS];
  logic [CHANNELS-1:0]   armed_q, flags_q, pins_q;
  logic [SEL_BITS-1:0]   div_sel;

  mct_out_t status_q [$];   // status words owed by the block, oldest first
  int err_count = 0;
  bit no_gaps   = 1'b0;     // both sides run back to back while set
  int hold_req_len = 0;
  int hold_req_id  = 0;
  int hold_seen    = 0;
  int hold_left    = 0;

  function automatic int unsigned ticks_per_count(input logic [SEL_BITS-1:0] sel);
    case (sel)
      PRE_DIV8:   return 8;
      PRE_DIV64:  return 64;
      PRE_DIV256: return 256;
      default:    return 1;
    endcase
  endfunction

  function automatic void reset_timer_model();
    tmr_count  = '0;
    tick_count = 0;
    for (int k = 0; k < CHANNELS; k++) begin
      cmp_val[k]  = '1;
      step_val[k] = '1;
    end
    armed_q = '0;
    flags_q = '0;
    pins_q  = '1;
    div_sel = PRE_DIV1;
  endfunction

  // Apply one transaction to the model and return the status it reports
  function automatic mct_out_t compute_status(input mct_in_t t);
    logic [CHANNELS-1:0] fired;
    mct_out_t            r;
    fired = '0;
    case (t.action)
      ACT_TICK: begin
        if (tick_count + 1 >= ticks_per_count(div_sel)) begin
          tick_count = 0;
          tmr_count  = tmr_count + 1'b1;
          for (int k = 0; k < CHANNELS; k++) begin
            if (cmp_val[k] == tmr_count) begin
              pins_q[k] = 1'b0;
              if (armed_q[k]) begin
                fired[k]   = 1'b1;
                cmp_val[k] = cmp_val[k] + step_val[k];
              end else begin
                flags_q[k] = 1'b1;
              end
            end
          end
        end else begin
          tick_count = (tick_count + 1) & 8'hff;
        end
      end
      ACT_SET: begin
        if (t.channel < CHANNELS) begin
          step_val[t.channel] = t.period - 1'b1;
          cmp_val[t.channel]  = tmr_count + step_val[t.channel];
          armed_q[t.channel]  = 1'b0;
          flags_q[t.channel]  = 1'b0;
          pins_q[t.channel]   = 1'b1;
        end
      end
      ACT_ARM: begin
        if (t.channel < CHANNELS) begin
          flags_q[t.channel] = 1'b0;
          armed_q[t.channel] = 1'b1;
        end
      end
      default: ;
    endcase
    r.fired_mask   = fired;
    r.pending_mask = flags_q;
    r.pin_levels   = pins_q;
    r.timer_value  = tmr_count;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input mct_out_t want, input mct_out_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: %s: want fired=%h pend=%h pins=%h timer=%h, got fired=%h pend=%h pins=%h timer=%h",
               $time, what, want.fired_mask, want.pending_mask, want.pin_levels,
               want.timer_value, got.fired_mask, got.pending_mask, got.pin_levels,
               got.timer_value);
  endtask

  // Scoreboard: check results, track config writes, predict accepted transactions
  always @(posedge clk) begin : scoreboard
    mct_out_t want;
    if (!rst_n) begin
      reset_timer_model();
      status_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          report_mismatch("result with no transaction outstanding", '0, out_data);
        end else begin
          want = status_q.pop_front();
          if (out_data.fired_mask !== want.fired_mask ||
              out_data.pending_mask !== want.pending_mask ||
              out_data.pin_levels !== want.pin_levels ||
              out_data.timer_value !== want.timer_value)
            report_mismatch("status mismatch", want, out_data);
        end
      end
      if (cfg_we)
        div_sel = cfg_data;
      if (in_valid && !in_stall)
        status_q.push_back(compute_status(in_data));
    end
  end

  // Result side: random stalls, plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_seen != hold_req_id) begin
      hold_seen = hold_req_id;
      hold_left = hold_req_len;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (no_gaps) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Offer one transaction and hold it until accepted
  task automatic send_item(input logic [ACTION_BITS-1:0] act, input logic [CHAN_BITS-1:0] ch,
                           input logic [PERIOD_BITS-1:0] per);
    mct_in_t t;
    t.action  = act;
    t.channel = ch;
    t.period  = per;
    @(negedge clk);
    if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(ACT_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
  endtask

  // Stop offering and wait until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_prescale(input logic [SEL_BITS-1:0] sel);
    drain_results();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= sel;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Every action, period extremes, bad channels and the unused action code
  task automatic test_directed_actions();
    send_item(ACT_TICK, 3'd0, 16'h0000);
    send_item(ACT_TICK, 3'd0, 16'h0000);
    send_item(ACT_TICK, 3'd7, 16'hffff);
    send_item(ACT_SET, 3'd0, 16'd4);
    send_item(ACT_ARM, 3'd0, 16'd0);
    send_ticks(4);
    send_item(ACT_SET, 3'd1, 16'h0000);   // period zero wraps the step
    send_item(ACT_SET, 3'd2, 16'hffff);
    send_item(ACT_SET, 3'd3, 16'd2);
    send_item(ACT_SET, 3'd4, 16'd1);
    // channels past the last one are ignored
    send_item(ACT_SET, 3'd5, 16'd7);
    send_item(ACT_ARM, 3'd6, 16'd0);
    send_item(ACT_SET, 3'd7, 16'hffff);
    send_item(ACT_ARM, 3'd7, 16'd0);
    send_item(ACT_UNUSED, 3'd2, 16'hffff);
    send_ticks(3);
    send_item(ACT_ARM, 3'd3, 16'd0);
    send_ticks(2);
  endtask

  // Each divide setting, and a divide change while the prescaler is mid-count
  task automatic test_prescaler();
    logic [SEL_BITS-1:0] plan [4];
    plan = '{PRE_DIV8, PRE_DIV64, PRE_DIV256, PRE_DIV1};
    send_item(ACT_SET, 3'd0, 16'd3);
    send_item(ACT_ARM, 3'd0, 16'd0);
    send_item(ACT_SET, 3'd1, 16'd2);
    foreach (plan[i]) begin
      write_prescale(plan[i]);
      send_ticks(ticks_per_count(plan[i]) + 5);
    end
    write_prescale(PRE_DIV256);
    send_ticks(100);
    write_prescale(PRE_DIV8);
    send_ticks(3);
    write_prescale(PRE_DIV256);
    send_ticks(200);
    write_prescale(PRE_DIV64);
    send_ticks(3);
    write_prescale(PRE_DIV1);
  endtask

  // Result side holds off long enough for the block to stall its input
  task automatic test_backpressure();
    drain_results();
    no_gaps      = 1'b1;
    hold_req_len = 64;
    hold_req_id++;
    send_item(ACT_SET, 3'd2, 16'd5);
    send_item(ACT_ARM, 3'd2, 16'd0);
    send_ticks(88);
    no_gaps = 1'b0;
    drain_results();
  endtask

  // Mostly ticks with sets and arms mixed in; small periods so channels fire often
  task automatic test_random_traffic();
    logic [SEL_BITS-1:0]    plan [8];
    logic [ACTION_BITS-1:0] act;
    logic [CHAN_BITS-1:0]   ch;
    logic [PERIOD_BITS-1:0] per;
    int                     pick;
    plan = '{PRE_DIV1, PRE_DIV256, PRE_DIV1, PRE_DIV8, PRE_DIV64, PRE_DIV1, PRE_DIV256,
             PRE_DIV8};
    foreach (plan[i]) begin
      write_prescale(plan[i]);
      no_gaps = (i == 2);
      repeat (110) begin
        pick = $urandom_range(0, 99);
        if (pick < 68)      act = ACT_TICK;
        else if (pick < 80) act = ACT_SET;
        else if (pick < 92) act = ACT_ARM;
        else                act = ACT_UNUSED;
        ch = ($urandom_range(0, 99) < 90) ? 3'($urandom_range(0, 4)) : 3'($urandom_range(5, 7));
        pick = $urandom_range(0, 99);
        if (pick < 55)      per = 16'($urandom_range(1, 24));
        else if (pick < 65) per = 16'($urandom_range(0, 1));
        else                per = 16'($urandom);
        send_item(act, ch, per);
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed_actions();
    test_prescaler();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

### multichannel_compare_timer.f
rtl/mct_pkg.sv
rtl/mct_timebase.sv
rtl/mct_channel.sv
rtl/multichannel_compare_timer.sv
verif/tb_top.sv
